// ===== design/crc32rsx_pkg.sv =====
`default_nettype none

package crc32rsx_pkg;

    // Generator polynomial in normal and bit-reversed (LSB-first) form
    localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_POLY_REFL = {<<{CRC_POLY}};

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 32;
    localparam int unsigned TABLE_N = 1 << BYTE_W;

    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef crc_t crc_table_t [TABLE_N];

    // One transaction as held in the input register
    typedef struct packed {
        byte_t data_byte;
        crc_t  seed_value;
        logic  first_byte;
        logic  last_byte;
    } crc_item_t;

    // Build the reflected table at elaboration: eight shift/XOR steps per entry
    function automatic crc_table_t gen_crc_table();
        crc_table_t tbl;
        crc_t       c;
        for (int i = 0; i < TABLE_N; i++) begin
            c = crc_t'(i);
            for (int k = 0; k < BYTE_W; k++) begin
                if (c[0]) begin
                    c = (c >> 1) ^ CRC_POLY_REFL;
                end else begin
                    c = c >> 1;
                end
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = gen_crc_table();

endpackage

`default_nettype wire

// ===== design/crc32rsx_step.sv =====
`default_nettype none

// One byte step of the reflected CRC: pick seed or running value, then one table lookup
module crc32rsx_step
    import crc32rsx_pkg::*;
(
    input  var crc_item_t item,
    input  var crc_t      running_crc,
    input  var crc_t      saved_seed,
    output var crc_t      crc_next,
    output var crc_t      seed_next,
    output var crc_t      result
);

    crc_t  crc_start;
    byte_t tbl_idx;

    always_comb begin
        crc_start = item.first_byte ? item.seed_value : running_crc;
        seed_next = item.first_byte ? item.seed_value : saved_seed;
        tbl_idx   = crc_start[BYTE_W-1:0] ^ item.data_byte;
        crc_next  = (crc_start >> BYTE_W) ^ CRC_TABLE[tbl_idx];
        result    = crc_next ^ seed_next;
    end

endmodule

`default_nettype wire

// ===== design/crc32rsx_top_note.sv =====
`default_nettype none

// Output holding stage: keeps a finished result until the receiver takes it
module crc32rsx_out
    import crc32rsx_pkg::*;
(
    input  var logic aclk,
    input  var logic aresetn,
    input  var logic load,
    input  var crc_t load_data,
    input  var logic take,
    output var logic valid,
    output var crc_t data
);

    logic out_valid_reg;
    crc_t out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= load_data;
        end
    end

    assign valid = out_valid_reg;
    assign data  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/crc32_reflected_seed_xor.sv =====
// Reflected CRC-32 (polynomial 0x04C11DB7, LSB-first), one byte per transaction.
// Input channel (s_*): each transaction carries one byte and a 32-bit seed in
// s_tdata, first-byte flag in s_tuser and last-byte flag in s_tlast. On a first
// byte the seed is loaded as the running CRC and remembered; every byte advances
// the CRC by one table step. On a last byte one result leaves on the m_* channel:
// the running CRC after that byte XOR the remembered seed. Bytes without last
// produce no output.
// A byte taken into the input register is folded into the running state, and its
// result, if any, is registered in the output holding stage and shown on m_tdata.
// Throughput: one byte per cycle unless a last byte waits behind an untaken result,
// set by the single table lookup and XOR between the input and result registers.
// Reset (aresetn low, synchronous) clears running CRC and saved seed to zero and
// drops any held transaction. When the receiver stalls, the result register
// holds; the input register still takes bytes without last, and s_tready falls
// only once a last byte waits behind an untaken result.
`default_nettype none

module crc32_reflected_seed_xor
    import crc32rsx_pkg::*;
(
    input  var logic        aclk,
    input  var logic        aresetn,
    input  var logic        s_tvalid,
    output var logic        s_tready,
    input  var logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] seed_value
    input  var logic        s_tuser,   // [0] first_byte
    input  var logic        s_tlast,   // last_byte
    output var logic        m_tvalid,
    input  var logic        m_tready,
    output var logic [31:0] m_tdata    // [31:0] crc_result
);

    // Input register
    logic      in_valid_reg;
    crc_item_t in_item_reg;

    // Algorithm state
    crc_t running_crc_reg;
    crc_t saved_seed_reg;

    crc_t crc_next;
    crc_t seed_next;
    crc_t result;
    logic step_fire;
    logic out_free;

    // Advance the held byte unless it is a last byte and the result slot is busy
    assign out_free  = !m_tvalid || m_tready;
    assign step_fire = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign s_tready  = !in_valid_reg || step_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.data_byte  <= s_tdata[7:0];
            in_item_reg.seed_value <= s_tdata[39:8];
            in_item_reg.first_byte <= s_tuser;
            in_item_reg.last_byte  <= s_tlast;
        end
    end

    crc32rsx_step u_step (
        .item        (in_item_reg),
        .running_crc (running_crc_reg),
        .saved_seed  (saved_seed_reg),
        .crc_next    (crc_next),
        .seed_next   (seed_next),
        .result      (result)
    );

    // Commit the step to the running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_crc_reg <= '0;
            saved_seed_reg  <= '0;
        end else if (step_fire) begin
            running_crc_reg <= crc_next;
            saved_seed_reg  <= seed_next;
        end
    end

    crc32rsx_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_fire && in_item_reg.last_byte),
        .load_data (result),
        .take      (m_tready),
        .valid     (m_tvalid),
        .data      (m_tdata)
    );

    // A result waiting on the receiver is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(step_fire && in_item_reg.last_byte))
        else $error("result overwritten while stalled");

    // A folded last byte always presents a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && in_item_reg.last_byte) |=> m_tvalid)
        else $error("last byte produced no result");

    // A first byte loads its seed into the saved seed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && in_item_reg.first_byte) |=>
            (saved_seed_reg == $past(in_item_reg.seed_value)))
        else $error("seed not captured on first byte");

    // A new result appears only after a last byte was folded in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid ##1 m_tvalid) |-> $past(step_fire && in_item_reg.last_byte))
        else $error("result without last byte");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
    import crc32rsx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous watchdog limit
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 700;
    // Random items after which both sides stop idling
    localparam int unsigned QUIET_AFTER  = 600;
    // Random item count at which the receiver starts its long hold-off
    localparam int unsigned HOLD_AT      = 250;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned N_DIR        = 20;

    // Reflected polynomial, built here rather than taken from the package table
    localparam crc_t POLY_LSB_FIRST = {<<{CRC_POLY}};

    // One row of the directed table; want is used only when fixed is set
    typedef struct {
        byte_t data;
        crc_t  seed;
        logic  first;
        logic  last;
        logic  fixed;
        crc_t  want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [7:0] data_byte, [39:8] seed_value
    logic        s_tuser;   // [0] first_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] crc_result

    // Predictor state: running CRC and the seed remembered at the first byte
    crc_t        crc_acc;
    crc_t        seed_held;
    // Expected buffer results, oldest first
    crc_t        pending_crc [$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned random_sent = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_req = 1'b0;

    // Directed stimulus: reset state, extremes, single-byte buffers, ignored
    // seeds, continuation after a last byte, a restart mid-buffer and the
    // well-known check string "123456789" with an all-ones seed
    dir_row_t dir_rows [N_DIR] = '{
        // byte with no first straight after reset: everything is still zero
        '{8'h00, 32'hDEAD_BEEF, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
        // single-byte buffer, all ones: index 0, CRC shifts to 0x00FFFFFF
        '{8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFF00_0000},
        // single-byte buffer, all zeros
        '{8'h00, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        '{8'hFF, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'h0},
        // three-byte buffer, seed on the later bytes must be ignored
        '{8'hFF, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h80, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h01, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
        // carry on after the last byte without a new first
        '{8'hAA, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0},
        // a second first in mid-buffer reloads both seed and CRC
        '{8'h55, 32'hA5A5_A5A5, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h5A, 32'h5A5A_5A5A, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h00, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
        // "123456789", seed all ones: result equals the standard check value
        '{8'h31, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h32, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h33, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h34, 32'h0F0F_0F0F, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h35, 32'hF0F0_F0F0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h36, 32'h8000_0001, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h37, 32'h7FFF_FFFE, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h38, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h39, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'hCBF4_3926}
    };

    crc32_reflected_seed_xor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Fold one byte into a CRC, bit by bit, LSB first
    function automatic crc_t crc_fold(input crc_t c, input byte_t d);
        crc_t r;
        r = c ^ crc_t'(d);
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ POLY_LSB_FIRST;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Advance the predictor by one accepted byte; return 1 if a result is due
    function automatic logic predict_byte(input byte_t d, input crc_t s, input logic f,
                                          input logic l, output crc_t res);
        if (f) begin
            crc_acc   = s;
            seed_held = s;
        end
        crc_acc = crc_fold(crc_acc, d);
        res     = crc_acc ^ seed_held;
        return l;
    endfunction

    // Offer one byte, hold it until the transaction completes, then record
    // the expected result (a typed-in value overrides the prediction)
    task automatic send_byte(input byte_t d, input crc_t s, input logic f, input logic l,
                             input logic use_want, input crc_t want);
        crc_t predicted;
        if (src_idle_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s, d};
        s_tuser  <= f;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_byte(d, s, f, l, predicted)) begin
            pending_crc.push_back(use_want ? want : predicted);
        end
    endtask

    // Random seed biased towards the extremes now and then
    function automatic crc_t pick_seed();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result checker: compare every result transaction with the oldest expectation
    always @(posedge aclk) begin
        crc_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_crc.size() == 0) begin
                $display("%0t: unexpected result, expected none, got crc_result %08h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_crc.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: crc_result mismatch, expected %08h, got %08h",
                             $time, want, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, long hold-offs on request, none at the end
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                // hold off long enough for the block to fill and stall its input
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Reset, stimulus and end of run
    initial begin
        int unsigned len;
        crc_t        seed;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        crc_acc   = '0;
        seed_held = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < N_DIR; i++) begin
            send_byte(dir_rows[i].data, dir_rows[i].seed, dir_rows[i].first,
                      dir_rows[i].last, dir_rows[i].fixed, dir_rows[i].want);
        end

        // random part: mostly whole buffers, some stray bytes with random flags
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= QUIET_AFTER) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            if (random_sent >= HOLD_AT && random_sent < HOLD_AT + 20 && !hold_req) begin
                hold_req = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) begin
                // mostly short buffers, the odd long one
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                seed = pick_seed();
                for (int b = 0; b < len; b++) begin
                    send_byte(byte_t'($urandom_range(0, 255)),
                              (b == 0) ? seed : crc_t'($urandom),
                              b == 0, b == len - 1, 1'b0, '0);
                    random_sent++;
                end
            end else begin
                send_byte(byte_t'($urandom_range(0, 255)), pick_seed(),
                          logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                          1'b0, '0);
                random_sent++;
            end
        end
        s_tvalid <= 1'b0;

        // drain: wait for every expected result, then let the pipeline settle
        while (pending_crc.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
